@@ rtl/gbn_pkg.sv @@
// Shared types and constants for the greedy box NMS block.
// No dependencies.
`timescale 1ns / 1ps
package gbn_pkg;

  localparam int MAX_BOXES_DEF   = 256;
  localparam int NUM_CLASSES_DEF = 64;

  localparam int SCORE_W = 16;
  localparam int CLS_W   = 6;
  localparam int POS_W   = 12;
  localparam int DIM_W   = 13;
  localparam int THR_W   = 16;

  localparam logic [15:0] CONF_RST = 16'd16384;
  localparam logic [15:0] OVLP_RST = 16'd29491;

  typedef enum logic {
    REG_CONF = 1'b0,
    REG_OVLP = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CLS_W-1:0]   cls;
    logic [POS_W-1:0]   left;
    logic [POS_W-1:0]   top;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
  } box_t;

  localparam int BOX_W  = $bits(box_t);
  localparam int WORD_W = BOX_W + 1;

endpackage

@@ rtl/gbn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/gbn_iou.sv @@
// Three-stage overlap test of a stored box against the kept box.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_iou import gbn_pkg::*; #(
  parameter int AW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              i_v,
  input  logic [AW-1:0]     i_idx,
  input  logic              i_done,
  input  box_t              i_box,
  input  box_t              k_box,
  input  logic [THR_W-1:0]  thr,
  output logic              o_v,
  output logic [AW-1:0]     o_idx,
  output logic              o_done,
  output box_t              o_box,
  output logic              o_sup
);

  logic [2:0]    v_r;
  logic [AW-1:0] idx_r [3];
  logic [2:0]    done_r;
  box_t          box_r [3];

  logic [13:0] lo_x, lo_y, hi_x, hi_y, rk, rb, bk, bb;
  logic [13:0] ix_r, iy_r;
  logic [27:0] inter2_r, inter3_r;
  logic [25:0] ab_r, ka_r;
  logic [26:0] uni;
  logic [42:0] prod_r;

  always_comb begin
    lo_x = (k_box.left > i_box.left) ? {2'b0, k_box.left} : {2'b0, i_box.left};
    lo_y = (k_box.top > i_box.top) ? {2'b0, k_box.top} : {2'b0, i_box.top};
    rk   = {2'b0, k_box.left} + {1'b0, k_box.w};
    rb   = {2'b0, i_box.left} + {1'b0, i_box.w};
    bk   = {2'b0, k_box.top} + {1'b0, k_box.h};
    bb   = {2'b0, i_box.top} + {1'b0, i_box.h};
    hi_x = (rk < rb) ? rk : rb;
    hi_y = (bk < bb) ? bk : bb;
    uni  = {1'b0, ka_r} + {1'b0, ab_r} - inter2_r[26:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], i_v};
    end
    idx_r[0]  <= i_idx;
    idx_r[1]  <= idx_r[0];
    idx_r[2]  <= idx_r[1];
    done_r    <= {done_r[1:0], i_done};
    box_r[0]  <= i_box;
    box_r[1]  <= box_r[0];
    box_r[2]  <= box_r[1];
    ix_r      <= (hi_x > lo_x) ? hi_x - lo_x : '0;
    iy_r      <= (hi_y > lo_y) ? hi_y - lo_y : '0;
    inter2_r  <= ix_r * iy_r;
    ab_r      <= box_r[0].w * box_r[0].h;
    ka_r      <= k_box.w * k_box.h;
    inter3_r  <= inter2_r;
    prod_r    <= thr * uni;
  end

  assign o_v    = v_r[2];
  assign o_idx  = idx_r[2];
  assign o_done = done_r[2];
  assign o_box  = box_r[2];
  assign o_sup  = {inter3_r, 16'b0} > {1'b0, prod_r};

endmodule

@@ rtl/greedy_box_nms_class_top1.sv @@
// Top level of the greedy box NMS block: load, sweep control, result output.
// Depends on gbn_pkg, gbn_ram, gbn_iou.
//
// channel  ports                                   handshake
// input    start, busy, in_*                       start & !busy
// result   out_valid, out_*                        out_valid, one cycle
// config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// Load: one candidate per cycle while not busy; each candidate that passes the filter and fits
// in the store takes one RAM write. Sweep after the final item: (K + 1) passes over the N stored
// boxes, K being the number of kept boxes; each pass streams the box RAM through the overlap unit.
// Reset is synchronous; no clearing pass is needed. Results cannot be stalled.
`timescale 1ns / 1ps
module greedy_box_nms_class_top1 import gbn_pkg::*; #(
  parameter int MAX_BOXES   = MAX_BOXES_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [SCORE_W-1:0] in_score,
  input  logic [CLS_W-1:0]   in_class_id,
  input  logic [POS_W-1:0]   in_left,
  input  logic [POS_W-1:0]   in_top,
  input  logic [DIM_W-1:0]   in_box_width,
  input  logic [DIM_W-1:0]   in_box_height,
  input  logic               in_final_item,
  output logic               out_valid,
  output logic               out_found,
  output logic [CLS_W-1:0]   out_class,
  output logic [SCORE_W-1:0] out_score,
  output logic [POS_W-1:0]   out_left,
  output logic [POS_W-1:0]   out_top,
  output logic [DIM_W-1:0]   out_width,
  output logic [DIM_W-1:0]   out_height,
  output logic               out_overflowed,
  output logic               out_run_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [THR_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_NEXT} state_t;

  state_t                 state_r;
  logic [THR_W-1:0]       conf_r, ovlp_r;
  logic [CW-1:0]          cnt_r, rd_i_r;
  logic                   ovf_r;
  logic [NUM_CLASSES-1:0] taken_r;
  logic [2:0]             drn_r;
  logic                   rd_v_r;
  logic [AW-1:0]          rd_idx_r;
  box_t                   k_box_r, best_box_r, hold_box_r, out_box_r;
  logic [AW-1:0]          k_idx_r, best_idx_r;
  logic                   k_v_r, best_v_r, hold_v_r;
  logic                   out_valid_r, out_found_r, out_run_end_r, out_ovf_r;

  box_t                   in_box;
  logic                   accept, pass, load_we, rd_en, wb_we, kill;
  logic [WORD_W-1:0]      rdata, wdata;
  logic [AW-1:0]          waddr;
  logic [NUM_CLASSES-1:0] best_bit;
  logic                   o_v, o_done, o_sup;
  logic [AW-1:0]          o_idx;
  box_t                   o_box;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_box    = '{score: in_score, cls: in_class_id, left: in_left, top: in_top,
                       w: in_box_width, h: in_box_height};
  assign pass      = (in_score >= conf_r) && (in_score != '0) && (in_box_width != '0) &&
                     (in_box_height != '0) && ({1'b0, in_class_id} < 7'(NUM_CLASSES));
  assign load_we   = accept && pass && (cnt_r < CW'(MAX_BOXES));
  assign rd_en     = (state_r == ST_SCAN) && (rd_i_r < cnt_r);
  assign kill      = k_v_r && (o_sup || (o_idx == k_idx_r));
  assign wb_we     = o_v && !o_done && kill;
  assign waddr     = load_we ? cnt_r[AW-1:0] : o_idx;
  assign wdata     = load_we ? {1'b0, in_box} : {1'b1, o_box};
  assign best_bit  = NUM_CLASSES'(1) << best_box_r.cls;

  gbn_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BOXES)) u_ram (
    .clk  (clk),
    .we   (load_we || wb_we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(rd_i_r[AW-1:0]),
    .rdata(rdata)
  );

  gbn_iou #(.AW(AW)) u_iou (
    .clk   (clk),
    .rst_n (rst_n),
    .i_v   (rd_v_r),
    .i_idx (rd_idx_r),
    .i_done(rdata[WORD_W-1]),
    .i_box (rdata[BOX_W-1:0]),
    .k_box (k_box_r),
    .thr   (ovlp_r),
    .o_v   (o_v),
    .o_idx (o_idx),
    .o_done(o_done),
    .o_box (o_box),
    .o_sup (o_sup)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      conf_r      <= CONF_RST;
      ovlp_r      <= OVLP_RST;
      cnt_r       <= '0;
      rd_i_r      <= '0;
      ovf_r       <= 1'b0;
      taken_r     <= '0;
      drn_r       <= '0;
      rd_v_r      <= 1'b0;
      k_v_r       <= 1'b0;
      best_v_r    <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_v_r      <= rd_en;
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_CONF: conf_r <= cfg_data;
          REG_OVLP: ovlp_r <= cfg_data;
          default: ;
        endcase
      end
      if (o_v && !o_done && !kill && (!best_v_r || o_box.score > best_box_r.score)) begin
        best_v_r   <= 1'b1;
        best_box_r <= o_box;
        best_idx_r <= o_idx;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (load_we) begin
              cnt_r <= cnt_r + 1'b1;
            end else if (pass) begin
              ovf_r <= 1'b1;
            end
            if (in_final_item) begin
              state_r  <= ST_SCAN;
              rd_i_r   <= '0;
              k_v_r    <= 1'b0;
              best_v_r <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_i_r <= rd_i_r + 1'b1;
          end else begin
            state_r <= ST_DRAIN;
            drn_r   <= '0;
          end
        end
        ST_DRAIN: begin
          drn_r <= drn_r + 1'b1;
          if (drn_r == 3'd5) begin
            state_r <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (best_v_r) begin
            k_box_r  <= best_box_r;
            k_idx_r  <= best_idx_r;
            k_v_r    <= 1'b1;
            best_v_r <= 1'b0;
            rd_i_r   <= '0;
            state_r  <= ST_SCAN;
            if ((taken_r & best_bit) == '0) begin
              taken_r    <= taken_r | best_bit;
              hold_box_r <= best_box_r;
              hold_v_r   <= 1'b1;
              if (hold_v_r) begin
                out_valid_r   <= 1'b1;
                out_found_r   <= 1'b1;
                out_box_r     <= hold_box_r;
                out_run_end_r <= 1'b0;
              end
            end
          end else begin
            out_valid_r   <= 1'b1;
            out_found_r   <= hold_v_r;
            out_box_r     <= hold_v_r ? hold_box_r : '0;
            out_run_end_r <= 1'b1;
            hold_v_r      <= 1'b0;
            k_v_r         <= 1'b0;
            taken_r       <= '0;
            cnt_r         <= '0;
            ovf_r         <= 1'b0;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_i_r[AW-1:0];
    if (state_r == ST_NEXT) begin
      out_ovf_r <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_class      = out_box_r.cls;
  assign out_score      = out_box_r.score;
  assign out_left       = out_box_r.left;
  assign out_top        = out_box_r.top;
  assign out_width      = out_box_r.w;
  assign out_height     = out_box_r.h;
  assign out_overflowed = out_ovf_r;
  assign out_run_end    = out_run_end_r;

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_end |-> !busy) else $error("run end while busy");
  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_run_end) else $error("empty result not last");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_BOXES)) else $error("store count overrun");
  a_wb_range: assert property (@(posedge clk) disable iff (!rst_n)
    wb_we |-> CW'(o_idx) < cnt_r) else $error("write back beyond store");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for greedy_box_nms_class_top1: frames of candidate boxes
// are checked against a scoreboard that keeps its own copy of the store, ranking and sweep.
// Depends on gbn_pkg and the block RTL.
`timescale 1ns / 1ps

class nms_scoreboard;
  typedef struct packed {
    bit        found;
    bit [5:0]  cls;
    bit [15:0] score;
    bit [11:0] left;
    bit [11:0] top;
    bit [12:0] w;
    bit [12:0] h;
    bit        ovf;
    bit        run_end;
  } nms_result_t;

  bit [15:0]        conf_thr;
  bit [15:0]        ovlp_thr;
  gbn_pkg::box_t    boxes[gbn_pkg::MAX_BOXES_DEF];
  int               rank_order[gbn_pkg::MAX_BOXES_DEF];
  int               box_count;
  bit               store_overflow;
  nms_result_t      pending_results[$];
  int               errors;
  int               results_seen;
  int               frames_done;
  int               overflow_frames;

  function new();
    conf_thr = gbn_pkg::CONF_RST;
    ovlp_thr = gbn_pkg::OVLP_RST;
    box_count = 0;
    store_overflow = 0;
    errors = 0;
    results_seen = 0;
    frames_done = 0;
    overflow_frames = 0;
  endfunction

  function bit boxes_overlap(gbn_pkg::box_t a, gbn_pkg::box_t b);
    longint unsigned lo_x, hi_x, lo_y, hi_y, ra, rb, ba, bb, ix, iy, inter, uni;
    ra = longint'(a.left) + a.w;
    rb = longint'(b.left) + b.w;
    ba = longint'(a.top) + a.h;
    bb = longint'(b.top) + b.h;
    lo_x = (a.left > b.left) ? a.left : b.left;
    hi_x = (ra < rb) ? ra : rb;
    lo_y = (a.top > b.top) ? a.top : b.top;
    hi_y = (ba < bb) ? ba : bb;
    ix = (hi_x > lo_x) ? hi_x - lo_x : 0;
    iy = (hi_y > lo_y) ? hi_y - lo_y : 0;
    inter = ix * iy;
    uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
    return inter * 65536 > longint'(ovlp_thr) * uni;
  endfunction

  function void note_item(gbn_pkg::box_t b, bit final_item);
    int pos, k, a;
    bit [gbn_pkg::MAX_BOXES_DEF-1:0] suppressed;
    bit [63:0] taken;
    nms_result_t r;
    if (b.score >= conf_thr && b.score != 0 && b.w != 0 && b.h != 0) begin
      if (box_count < gbn_pkg::MAX_BOXES_DEF) begin
        boxes[box_count] = b;
        pos = box_count;
        while (pos > 0 && boxes[rank_order[pos-1]].score < b.score) begin
          rank_order[pos] = rank_order[pos-1];
          pos--;
        end
        rank_order[pos] = box_count;
        box_count++;
      end else begin
        store_overflow = 1;
      end
    end
    if (!final_item) return;
    suppressed = '0;
    taken = '0;
    k = 0;
    for (int i = 0; i < box_count; i++) begin
      a = rank_order[i];
      if (suppressed[a]) continue;
      if (!taken[boxes[a].cls] && k < 64) begin
        taken[boxes[a].cls] = 1;
        r = '{1'b1, boxes[a].cls, boxes[a].score, boxes[a].left, boxes[a].top,
              boxes[a].w, boxes[a].h, store_overflow, 1'b0};
        pending_results = {pending_results, r};
        k++;
      end
      for (int j = i + 1; j < box_count; j++)
        if (!suppressed[rank_order[j]] && boxes_overlap(boxes[a], boxes[rank_order[j]]))
          suppressed[rank_order[j]] = 1;
    end
    if (k == 0) begin
      r = '{1'b0, 6'd0, 16'd0, 12'd0, 12'd0, 13'd0, 13'd0, store_overflow, 1'b0};
      pending_results = {pending_results, r};
    end
    pending_results[pending_results.size()-1].run_end = 1;
    if (store_overflow) overflow_frames++;
    frames_done++;
    box_count = 0;
    store_overflow = 0;
  endfunction

  function void check_result(nms_result_t got);
    nms_result_t e;
    results_seen++;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result found=%0d class=%0d score=%0d",
               $time, got.found, got.cls, got.score);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (got !== e) begin
      $display("%0t: mismatch expected f=%0d c=%0d s=%0d l=%0d t=%0d w=%0d h=%0d o=%0d e=%0d",
               $time, e.found, e.cls, e.score, e.left, e.top, e.w, e.h, e.ovf, e.run_end);
      $display("%0t:          actual   f=%0d c=%0d s=%0d l=%0d t=%0d w=%0d h=%0d o=%0d e=%0d",
               $time, got.found, got.cls, got.score, got.left, got.top, got.w, got.h,
               got.ovf, got.run_end);
      errors++;
    end
  endfunction
endclass

module tb_top import gbn_pkg::*; ();

  localparam int IDLE_LIMIT = 400000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              start = 0;
  logic              busy;
  logic [SCORE_W-1:0] in_score = '0;
  logic [CLS_W-1:0]  in_class_id = '0;
  logic [POS_W-1:0]  in_left = '0;
  logic [POS_W-1:0]  in_top = '0;
  logic [DIM_W-1:0]  in_box_width = '0;
  logic [DIM_W-1:0]  in_box_height = '0;
  logic              in_final_item = 0;
  logic              out_valid, out_found, out_overflowed, out_run_end;
  logic [CLS_W-1:0]  out_class;
  logic [SCORE_W-1:0] out_score;
  logic [POS_W-1:0]  out_left, out_top;
  logic [DIM_W-1:0]  out_width, out_height;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  reg_idx_t          cfg_index = REG_CONF;
  logic [THR_W-1:0]  cfg_data = '0;

  nms_scoreboard sb = new();
  int            idle_cycles = 0;
  int            items_sent = 0;
  bit            no_gaps = 0;

  greedy_box_nms_class_top1 dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_found, out_class, out_score, out_left, out_top, out_width,
                        out_height, out_overflowed, out_run_end});
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_box(int score, int cls, int left, int top, int w, int h, bit fin);
    gbn_pkg::box_t b;
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    b = '{SCORE_W'(score), CLS_W'(cls), POS_W'(left), POS_W'(top), DIM_W'(w), DIM_W'(h)};
    start <= 1;
    in_score <= b.score;
    in_class_id <= b.cls;
    in_left <= b.left;
    in_top <= b.top;
    in_box_width <= b.w;
    in_box_height <= b.h;
    in_final_item <= fin;
    do @(posedge clk); while (busy);
    sb.note_item(b, fin);
    items_sent++;
    if (fin) begin
      start <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= THR_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_CONF) sb.conf_thr = 16'(value);
    else sb.ovlp_thr = 16'(value);
  endtask

  task automatic send_random_box(bit fin);
    int s, c, l, t, w, h;
    case ($urandom_range(0, 9))
      0: s = 0;
      1: s = 16'hFFFF;
      2: s = sb.conf_thr;
      3: s = $urandom_range(0, 65535);
      4: s = 40000 + $urandom_range(0, 3) * 1000;
      default: s = $urandom_range(65535, sb.conf_thr);
    endcase
    c = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 63);
    l = ($urandom_range(0, 9) < 7) ? $urandom_range(100, 160) : $urandom_range(0, 4095);
    t = ($urandom_range(0, 9) < 7) ? $urandom_range(100, 160) : $urandom_range(0, 4095);
    case ($urandom_range(0, 9))
      0: w = 0;
      1: w = $urandom_range(0, 8191);
      default: w = $urandom_range(1, 80);
    endcase
    case ($urandom_range(0, 9))
      0: h = 0;
      1: h = $urandom_range(0, 8191);
      default: h = $urandom_range(1, 80);
    endcase
    send_box(s, c, l, t, w, h, fin);
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // a lone dropped candidate leaves only an empty end-of-run result
    send_box(0, 5, 10, 10, 20, 20, 1);
    send_box(16383, 5, 10, 10, 20, 20, 1);
    // zero width, zero height, threshold edge, extreme fields
    send_box(16384, 0, 0, 0, 0, 9, 0);
    send_box(30000, 1, 0, 0, 9, 0, 0);
    send_box(16384, 2, 0, 0, 1, 1, 0);
    send_box(65535, 63, 4095, 4095, 4096, 4096, 0);
    send_box(50000, 63, 4095, 4095, 8191, 8191, 1);
    // ties in score, overlap suppression within and across classes
    send_box(40000, 3, 100, 100, 50, 50, 0);
    send_box(40000, 3, 300, 300, 50, 50, 0);
    send_box(45000, 4, 102, 102, 50, 50, 0);
    send_box(44000, 3, 101, 101, 50, 50, 0);
    send_box(60000, 7, 2000, 1000, 100, 100, 1);
    write_reg(REG_CONF, 0);
    write_reg(REG_OVLP, 0);
    send_box(1, 9, 0, 0, 1, 1, 0);
    send_box(1, 10, 0, 0, 1, 1, 0);
    send_box(2, 11, 5, 5, 1, 1, 1);
    write_reg(REG_CONF, 65535);
    write_reg(REG_OVLP, 65535);
    send_box(65535, 1, 7, 7, 30, 30, 0);
    send_box(65535, 2, 7, 7, 30, 30, 0);
    send_box(65534, 3, 7, 7, 30, 30, 1);
    write_reg(REG_CONF, CONF_RST);
    write_reg(REG_OVLP, OVLP_RST);

    // fill the store past capacity
    no_gaps = 1;
    for (int i = 0; i < 259; i++)
      send_box($urandom_range(65535, 16384), $urandom_range(0, 63), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(1, 4096), $urandom_range(1, 4096),
               i == 258);

    while (items_sent < 430) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_CONF, $urandom_range(0, 65535));
          1: write_reg(REG_OVLP, $urandom_range(0, 65535));
          2: write_reg(REG_CONF, $urandom_range(0, 1) ? 0 : 65535);
          default: write_reg(REG_OVLP, $urandom_range(10000, 50000));
        endcase
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 14);
      for (int i = 0; i < n; i++) send_random_box(i == n - 1);
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d candidates in %0d frames, %0d results, %0d frames with overflow.",
             items_sent, sb.frames_done, sb.results_seen, sb.overflow_frames);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
